[hdl/bdd_pkg.sv]
// shared constants and types for the button debounce and double press unit
package bdd_pkg;

    localparam int TIME_WIDTH      = 32;
    localparam int NOW_WIDTH       = 32;
    localparam int MS_WIDTH        = 16;
    localparam int COUNT_WIDTH     = 2;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int S_TDATA_WIDTH   = 40;
    localparam int M_TDATA_WIDTH   = 8;

    localparam logic [MS_WIDTH-1:0] DEBOUNCE_RESET = MS_WIDTH'(50);
    localparam logic [MS_WIDTH-1:0] WINDOW_RESET   = MS_WIDTH'(300);

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [MS_WIDTH-1:0]    ms_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW   = 1'b1;

    // poll kinds carried in s_tuser
    localparam logic FUNC_PRESS   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam count_t COUNT_NONE   = 2'd0;
    localparam count_t COUNT_ONE    = 2'd1;
    localparam count_t COUNT_DOUBLE = 2'd2;

    typedef struct packed {
        logic   pressed;
        logic   released;
        logic   double_pressed;
        count_t press_count;
    } result_t;

endpackage

[hdl/button_debounce_double_press_unit.sv]
// top level: debounced button state and double press count, one poll per transfer
//
// Each input transfer is one poll and gives exactly one result transfer. A poll
// is captured in an input register and resolved combinationally against the
// debounce state into the result register that drives m_tvalid, so the block
// sustains one poll per clock while m_tready does not stall the output. The
// result register and the input register decouple the two sides, and a stall
// on m_tready holds a poll in the input register only once the result register
// is full.
module button_debounce_double_press_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] button_low, [32:1] now_ms, [39:33] zero
    input  logic [bdd_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // [0] func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] pressed, [1] released, [2] double_pressed, [4:3] press_count, [7:5] zero
    output logic [bdd_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bdd_pkg::MS_WIDTH-1:0]        cfg_data
);

    bdd_pkg::ms_t      debounce_reg;
    bdd_pkg::ms_t      window_reg;

    logic              in_valid_reg;
    logic              in_func_reg;
    logic              in_button_low_reg;
    bdd_pkg::time_t    in_now_reg;

    logic              held_reg, held_next;
    bdd_pkg::time_t    last_active_reg, last_active_next;
    bdd_pkg::count_t   count_reg, count_next;
    bdd_pkg::time_t    first_release_reg, first_release_next;

    logic              out_valid_reg;
    bdd_pkg::result_t  out_reg, out_next;

    logic              fire;
    logic              down;
    logic              released;
    logic              debounced;
    logic              in_window;
    bdd_pkg::time_t    since_active;
    bdd_pkg::time_t    since_release;
    bdd_pkg::time_t    since_release_new;
    bdd_pkg::time_t    window_ext;
    bdd_pkg::count_t   count_mid;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = bdd_pkg::M_TDATA_WIDTH'({out_reg.press_count, out_reg.double_pressed,
                                                 out_reg.released, out_reg.pressed});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bdd_pkg::DEBOUNCE_RESET;
            window_reg   <= bdd_pkg::WINDOW_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bdd_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                bdd_pkg::CFG_WINDOW:   window_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg       <= s_tuser;
            in_button_low_reg <= s_tdata[0];
            in_now_reg        <= bdd_pkg::TIME_WIDTH'(s_tdata[bdd_pkg::NOW_WIDTH:1]);
        end
    end

    // time differences wrap at the time width
    assign down              = !in_button_low_reg;
    assign window_ext        = bdd_pkg::TIME_WIDTH'(window_reg);
    assign since_active      = in_now_reg - last_active_reg;
    assign since_release     = in_now_reg - first_release_reg;
    assign debounced         = since_active > bdd_pkg::TIME_WIDTH'(debounce_reg);
    assign count_mid         = (count_reg == bdd_pkg::COUNT_NONE) ? bdd_pkg::COUNT_ONE
                                                                  : count_reg;
    assign in_window         = (first_release_reg != '0) && (since_release < window_ext);
    assign since_release_new = in_now_reg - first_release_next;

    always_comb begin
        held_next          = held_reg;
        last_active_next   = last_active_reg;
        count_next         = count_reg;
        first_release_next = first_release_reg;
        released           = 1'b0;
        unique case (in_func_reg)
            bdd_pkg::FUNC_PRESS: begin
                if (down) begin
                    held_next        = 1'b1;
                    last_active_next = in_now_reg;
                    count_next       = count_mid;
                    if (count_mid == bdd_pkg::COUNT_ONE && in_window) begin
                        count_next = bdd_pkg::COUNT_DOUBLE;
                    end
                end else if (debounced) begin
                    held_next = 1'b0;
                    // first debounced release opens the window
                    if (count_reg == bdd_pkg::COUNT_ONE && first_release_reg == '0) begin
                        first_release_next = in_now_reg;
                    end
                end
            end
            bdd_pkg::FUNC_RELEASE: begin
                if (down) begin
                    held_next        = 1'b1;
                    last_active_next = in_now_reg;
                end else if (held_reg && debounced) begin
                    held_next = 1'b0;
                    released  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // sequence ends after a double press or once the window has expired
    logic seq_end;
    assign seq_end = (in_func_reg == bdd_pkg::FUNC_PRESS) && !down && debounced &&
                     ((count_reg == bdd_pkg::COUNT_DOUBLE) ||
                      (count_reg == bdd_pkg::COUNT_ONE && since_release_new > window_ext));

    bdd_pkg::count_t count_final;
    bdd_pkg::time_t  first_release_final;
    assign count_final         = seq_end ? bdd_pkg::COUNT_NONE : count_next;
    assign first_release_final = seq_end ? '0 : first_release_next;

    always_comb begin
        out_next.pressed        = held_next;
        out_next.released       = released;
        out_next.double_pressed = (count_final == bdd_pkg::COUNT_DOUBLE);
        out_next.press_count    = count_final;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg          <= 1'b0;
            last_active_reg   <= '0;
            count_reg         <= bdd_pkg::COUNT_NONE;
            first_release_reg <= '0;
        end else if (fire) begin
            held_reg          <= held_next;
            last_active_reg   <= last_active_next;
            count_reg         <= count_final;
            first_release_reg <= first_release_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

endmodule

[hdl/bdd_checker.sv]
// port level checks for the button debounce and double press unit, with bind
module bdd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [bdd_pkg::M_TDATA_WIDTH-1:0]  m_tdata
);

    // count saturates at a double press
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:3] != 2'd3))
        else $error("press count out of range");

    a_double_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == (m_tdata[4:3] == bdd_pkg::COUNT_DOUBLE)))
        else $error("double press flag does not match count");

    // a debounced release always leaves the button not pressed
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("release reported while still pressed");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed during stall");

endmodule

bind button_debounce_double_press_unit bdd_checker u_bdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/button_debounce_double_press_unit_test.sv]
// self-checking testbench for the button debounce and double press unit
module button_debounce_double_press_unit_test;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_POLLS = 334;
    localparam int PHASE_COUNT = 6;
    localparam int ROW_COUNT   = 23;

    // same bit order as m_tdata, pressed in the lowest bit
    typedef struct packed {
        bdd_pkg::count_t press_count;
        logic            double_pressed;
        logic            released;
        logic            pressed;
    } poll_result_t;

    typedef struct packed {
        logic           func;
        logic           button_low;
        bdd_pkg::time_t now;
        logic           typed;
        poll_result_t   result;
    } poll_row_t;

    localparam poll_result_t IDLE_RESULT = '0;
    localparam poll_result_t HELD_ONE = '{press_count: bdd_pkg::COUNT_ONE,
                                          double_pressed: 1'b0,
                                          released: 1'b0, pressed: 1'b1};
    localparam poll_result_t RELEASED_ONE = '{press_count: bdd_pkg::COUNT_ONE,
                                              double_pressed: 1'b0,
                                              released: 1'b1, pressed: 1'b0};
    localparam poll_result_t HELD_DOUBLE = '{press_count: bdd_pkg::COUNT_DOUBLE,
                                             double_pressed: 1'b1,
                                             released: 1'b0, pressed: 1'b1};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [bdd_pkg::S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [bdd_pkg::M_TDATA_WIDTH-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [bdd_pkg::MS_WIDTH-1:0] cfg_data = '0;

    button_debounce_double_press_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // debouncer mirror
    bdd_pkg::ms_t    debounce_q = bdd_pkg::DEBOUNCE_RESET;
    bdd_pkg::ms_t    window_q = bdd_pkg::WINDOW_RESET;
    logic            held_q = 1'b0;
    bdd_pkg::time_t  last_active_q = '0;
    bdd_pkg::count_t count_q = bdd_pkg::COUNT_NONE;
    bdd_pkg::time_t  first_release_q = '0;

    poll_result_t expected_results [$];
    poll_result_t got_result;
    poll_result_t want_result;
    int mismatch_count = 0;
    int stall_cycles = 0;
    int send_idle_pct = 28;
    int recv_idle_pct = 74;
    int phase_polls = 0;
    bdd_pkg::time_t clock_ms = '0;

    poll_row_t directed_rows [0:ROW_COUNT-1] = '{
        '{bdd_pkg::FUNC_RELEASE, 1'b1, 32'd10,  1'b1, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'd20,  1'b1, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'd100, 1'b1, HELD_ONE},
        // second press before any release is stored
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'd120, 1'b0, IDLE_RESULT},
        // inactive for exactly the debounce time
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'd170, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_RELEASE, 1'b1, 32'd171, 1'b1, RELEASED_ONE},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'd171, 1'b0, IDLE_RESULT},
        // second press at exactly the window
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'd471, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'd522, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'd600, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'd700, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'd800, 1'b1, HELD_DOUBLE},
        '{bdd_pkg::FUNC_RELEASE, 1'b0, 32'd810, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_RELEASE, 1'b1, 32'd900, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'd901, 1'b0, IDLE_RESULT},
        // timestamps wrapping through zero
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'hFFFF_FFF0, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'h0000_0030, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'h0000_0100, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'h0000_0200, 1'b0, IDLE_RESULT},
        // first release lands on time zero and reads as none stored
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'hFFFF_FF00, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'h0000_0000, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b1, 32'h0000_0005, 1'b0, IDLE_RESULT},
        '{bdd_pkg::FUNC_PRESS,   1'b0, 32'hFFFF_FFFF, 1'b0, IDLE_RESULT}
    };

    function automatic poll_result_t resolve_poll(logic func, logic button_low,
                                                  bdd_pkg::time_t now);
        poll_result_t r;
        r = '0;
        if (func == bdd_pkg::FUNC_PRESS) begin
            if (!button_low) begin
                held_q = 1'b1;
                last_active_q = now;
                if (count_q == bdd_pkg::COUNT_NONE)
                    count_q = bdd_pkg::COUNT_ONE;
                if (count_q == bdd_pkg::COUNT_ONE && first_release_q != '0 &&
                    bdd_pkg::time_t'(now - first_release_q) < bdd_pkg::time_t'(window_q))
                    count_q = bdd_pkg::COUNT_DOUBLE;
            end else if (bdd_pkg::time_t'(now - last_active_q) >
                         bdd_pkg::time_t'(debounce_q)) begin
                held_q = 1'b0;
                if (count_q == bdd_pkg::COUNT_ONE && first_release_q == '0)
                    first_release_q = now;
                if (count_q == bdd_pkg::COUNT_DOUBLE || (count_q == bdd_pkg::COUNT_ONE &&
                    bdd_pkg::time_t'(now - first_release_q) >
                    bdd_pkg::time_t'(window_q))) begin
                    count_q = bdd_pkg::COUNT_NONE;
                    first_release_q = '0;
                end
            end
        end else begin
            if (!button_low) begin
                last_active_q = now;
                held_q = 1'b1;
            end else if (held_q && bdd_pkg::time_t'(now - last_active_q) >
                         bdd_pkg::time_t'(debounce_q)) begin
                r.released = 1'b1;
                held_q = 1'b0;
            end
        end
        r.pressed = held_q;
        r.double_pressed = (count_q == bdd_pkg::COUNT_DOUBLE);
        r.press_count = count_q;
        return r;
    endfunction

    // gap that lands on, just around, anywhere inside or well past a time span
    function automatic bdd_pkg::time_t near_gap(bdd_pkg::ms_t span);
        case ($urandom_range(4))
            0: return bdd_pkg::time_t'(span);
            1: return bdd_pkg::time_t'(span) + bdd_pkg::time_t'(1);
            2: return bdd_pkg::time_t'(span) - bdd_pkg::time_t'(1);
            3: return bdd_pkg::time_t'($urandom_range(0, int'(span)));
            default: return bdd_pkg::time_t'(span) + bdd_pkg::time_t'($urandom_range(2, 400));
        endcase
    endfunction

    task automatic send_poll(input logic func, input logic button_low,
                             input bdd_pkg::time_t now,
                             input logic typed = 1'b0, input poll_result_t typed_result = '0);
        poll_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= bdd_pkg::S_TDATA_WIDTH'({now, button_low});
        s_tuser <= func;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = resolve_poll(func, button_low, now);
        expected_results.push_back(typed ? typed_result : predicted);
        phase_polls++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [bdd_pkg::CFG_INDEX_WIDTH-1:0] index,
                             input bdd_pkg::ms_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (index == bdd_pkg::CFG_DEBOUNCE)
            debounce_q = value;
        else
            window_q = value;
    endtask

    task automatic set_config(input bdd_pkg::ms_t debounce, input bdd_pkg::ms_t window);
        write_reg(bdd_pkg::CFG_DEBOUNCE, debounce);
        write_reg(bdd_pkg::CFG_WINDOW, window);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // bouncy press, settle, and sometimes a second press near the window
    task automatic press_gesture();
        int bounces;
        bounces = $urandom_range(0, 3);
        repeat (bounces) begin
            send_poll(($urandom_range(3) == 0) ? bdd_pkg::FUNC_RELEASE : bdd_pkg::FUNC_PRESS,
                      ($urandom_range(3) == 0), clock_ms);
            clock_ms = clock_ms + bdd_pkg::time_t'($urandom_range(0, int'(debounce_q)));
        end
        send_poll(bdd_pkg::FUNC_PRESS, 1'b0, clock_ms);
        clock_ms = clock_ms + near_gap(debounce_q);
        if ($urandom_range(1))
            send_poll(bdd_pkg::FUNC_RELEASE, 1'b1, clock_ms);
        send_poll(bdd_pkg::FUNC_PRESS, 1'b1, clock_ms);
        if ($urandom_range(2) != 0) begin
            clock_ms = clock_ms + near_gap(window_q);
            send_poll(bdd_pkg::FUNC_PRESS, 1'b0, clock_ms);
            clock_ms = clock_ms + near_gap(debounce_q);
            if ($urandom_range(1))
                send_poll(bdd_pkg::FUNC_RELEASE, 1'b1, clock_ms);
            send_poll(bdd_pkg::FUNC_PRESS, 1'b1, clock_ms);
        end
        clock_ms = clock_ms + bdd_pkg::time_t'($urandom_range(0, 3 * int'(window_q) + 10));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: m_tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want_result = expected_results.pop_front();
                got_result = poll_result_t'(m_tdata[4:0]);
                if (got_result.pressed !== want_result.pressed) begin
                    $error("pressed: expected %0d, got %0d",
                           want_result.pressed, got_result.pressed);
                    mismatch_count++;
                end
                if (got_result.released !== want_result.released) begin
                    $error("released: expected %0d, got %0d",
                           want_result.released, got_result.released);
                    mismatch_count++;
                end
                if (got_result.double_pressed !== want_result.double_pressed) begin
                    $error("double_pressed: expected %0d, got %0d",
                           want_result.double_pressed, got_result.double_pressed);
                    mismatch_count++;
                end
                if (got_result.press_count !== want_result.press_count) begin
                    $error("press_count: expected %0d, got %0d",
                           want_result.press_count, got_result.press_count);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("button_debounce_double_press_unit_test NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int phase;
        int row;
        bit drained_once;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_config(bdd_pkg::DEBOUNCE_RESET, bdd_pkg::WINDOW_RESET);

        for (row = 0; row < ROW_COUNT; row++)
            send_poll(directed_rows[row].func, directed_rows[row].button_low,
                      directed_rows[row].now, directed_rows[row].typed,
                      directed_rows[row].result);
        wait_drain();

        clock_ms = bdd_pkg::time_t'($urandom());
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: set_config(bdd_pkg::ms_t'(0), bdd_pkg::ms_t'(0));
                1: set_config(bdd_pkg::ms_t'(16'hFFFF), bdd_pkg::ms_t'(16'hFFFF));
                2: set_config(bdd_pkg::DEBOUNCE_RESET, bdd_pkg::WINDOW_RESET);
                3: set_config(bdd_pkg::ms_t'($urandom_range(65535)),
                              bdd_pkg::ms_t'($urandom_range(65535)));
                4: set_config(bdd_pkg::ms_t'(3), bdd_pkg::ms_t'(10));
                default: set_config(bdd_pkg::ms_t'(16'hFFFF), bdd_pkg::ms_t'(0));
            endcase
            case (phase / 2)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_polls = 0;
            drained_once = 1'b0;
            while (phase_polls < PHASE_POLLS) begin
                if (!drained_once && phase_polls >= PHASE_POLLS / 2) begin
                    wait_drain();
                    drained_once = 1'b1;
                end
                if ($urandom_range(4) == 0) begin
                    // noise: any poll at any time, sometimes moving the clock along
                    send_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                              bdd_pkg::time_t'($urandom()));
                    if ($urandom_range(3) == 0)
                        clock_ms = bdd_pkg::time_t'($urandom());
                end else begin
                    press_gesture();
                end
            end
            wait_drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("button_debounce_double_press_unit_test OK");
        end else begin
            $display("button_debounce_double_press_unit_test NOT OK");
        end
        $finish;
    end

endmodule
